### rtl/f2prng_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 64-bit F2-linear generator.
package f2prng_pkg;

  localparam logic [63:0] TWIST_MATRIX = 64'h4fa9_ca36_f293_c9a9;
  localparam logic [63:0] TEMPER_MASK  = 64'h06fb_bee2_9aae_fd91;
  localparam logic [63:0] SEED_MULT    = 64'h5851_f42d_4c95_7f2d;
  localparam logic [63:0] LOWER_MASK   = 64'h0000_7fff_ffff_ffff;
  localparam logic [63:0] UPPER_MASK   = ~LOWER_MASK;

  localparam int unsigned MID_OFFSET   = 373;
  localparam int unsigned TEMPER_LAG   = 95;
  localparam int unsigned EXTRA_SHIFT  = 37;
  localparam int unsigned STORE_SHIFT  = 14;
  localparam int unsigned TEMPER_SHIFT = 6;
  localparam int unsigned SEED_SHIFT   = 62;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_NXT,
    RD_MID,
    RD_LAG
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SD_PUT,
    ST_SD_MIX,
    ST_SD_MUL0,
    ST_SD_MUL1,
    ST_SD_MUL2,
    ST_GN_RCUR,
    ST_GN_RNXT,
    ST_GN_RMID,
    ST_GN_RLAG,
    ST_GN_WR,
    ST_GN_OUT,
    ST_GN_ZERO
  } state_e;

  typedef struct packed {
    logic    seed_load;
    logic    sd_put;
    logic    sd_mix;
    logic    sd_mul0;
    logic    sd_mul1;
    logic    sd_mul2;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    gn_cap;
    logic    gn_join;
    logic    gn_mix;
    logic    gn_wr;
    logic    out_load;
    logic    out_zero;
  } cmd_t;

  typedef struct packed {
    logic idx_done;
    logic out_free;
  } sts_t;

endpackage

### rtl/f2prng_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for seeding and generation of the F2-linear generator.
module f2prng_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               func_i,
  output logic               in_stall_o,
  output f2prng_pkg::cmd_t   cmd_o,
  input  f2prng_pkg::sts_t   sts_i
);

  f2prng_pkg::state_e state_q, state_d;
  logic seeded_q, seeded_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= f2prng_pkg::ST_IDLE;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seeded_q <= seeded_d;
    end
  end

  assign in_stall_o = (state_q != f2prng_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    seeded_d = seeded_q;
    cmd_o    = '0;
    unique case (state_q)
      f2prng_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!func_i) begin
            cmd_o.seed_load = 1'b1;
            state_d         = f2prng_pkg::ST_SD_PUT;
          end else if (seeded_q) begin
            state_d = f2prng_pkg::ST_GN_RCUR;
          end else begin
            state_d = f2prng_pkg::ST_GN_ZERO;
          end
        end
      end
      f2prng_pkg::ST_SD_PUT: begin
        cmd_o.sd_put = 1'b1;
        if (sts_i.idx_done) begin
          seeded_d = 1'b1;
          state_d  = f2prng_pkg::ST_IDLE;
        end else begin
          state_d = f2prng_pkg::ST_SD_MIX;
        end
      end
      f2prng_pkg::ST_SD_MIX: begin
        cmd_o.sd_mix = 1'b1;
        state_d      = f2prng_pkg::ST_SD_MUL0;
      end
      f2prng_pkg::ST_SD_MUL0: begin
        cmd_o.sd_mul0 = 1'b1;
        state_d       = f2prng_pkg::ST_SD_MUL1;
      end
      f2prng_pkg::ST_SD_MUL1: begin
        cmd_o.sd_mul1 = 1'b1;
        state_d       = f2prng_pkg::ST_SD_MUL2;
      end
      f2prng_pkg::ST_SD_MUL2: begin
        cmd_o.sd_mul2 = 1'b1;
        state_d       = f2prng_pkg::ST_SD_PUT;
      end
      f2prng_pkg::ST_GN_RCUR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = f2prng_pkg::RD_CUR;
        state_d      = f2prng_pkg::ST_GN_RNXT;
      end
      f2prng_pkg::ST_GN_RNXT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = f2prng_pkg::RD_NXT;
        cmd_o.gn_cap = 1'b1;
        state_d      = f2prng_pkg::ST_GN_RMID;
      end
      f2prng_pkg::ST_GN_RMID: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = f2prng_pkg::RD_MID;
        cmd_o.gn_join = 1'b1;
        state_d       = f2prng_pkg::ST_GN_RLAG;
      end
      f2prng_pkg::ST_GN_RLAG: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = f2prng_pkg::RD_LAG;
        cmd_o.gn_mix = 1'b1;
        state_d      = f2prng_pkg::ST_GN_WR;
      end
      f2prng_pkg::ST_GN_WR: begin
        cmd_o.gn_wr = 1'b1;
        state_d     = f2prng_pkg::ST_GN_OUT;
      end
      f2prng_pkg::ST_GN_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = f2prng_pkg::ST_IDLE;
        end
      end
      f2prng_pkg::ST_GN_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = 1'b1;
          state_d        = f2prng_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = f2prng_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_gen_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == f2prng_pkg::ST_GN_RCUR |-> seeded_q)
    else $error("generation started without a seed");

  a_wr_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == f2prng_pkg::ST_GN_WR |=> state_q == f2prng_pkg::ST_GN_OUT)
    else $error("state write not followed by output stage");

  a_seeded_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seeded_q) |-> $past(state_q) == f2prng_pkg::ST_SD_PUT && $past(sts_i.idx_done))
    else $error("seeded flag set outside the end of seeding");
`endif

endmodule

### rtl/f2prng_dp.sv
`timescale 1ns / 1ps
// State memory, seed multiplier, twist and temper datapath, output register.
module f2prng_dp #(
  parameter int STATE_DEPTH = 695
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  f2prng_pkg::cmd_t   cmd_i,
  output f2prng_pkg::sts_t   sts_o,
  input  logic [63:0]        seed_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [63:0]        value_o
);

  localparam int AW = $clog2(STATE_DEPTH);
  localparam int IW = $clog2(STATE_DEPTH + 1);
  localparam logic [AW:0]   DepthW = (AW + 1)'(STATE_DEPTH);
  localparam logic [IW-1:0] DepthI = IW'(STATE_DEPTH);
  localparam logic [AW:0]   OffOne = (AW + 1)'(1);
  localparam logic [AW:0]   OffMid = (AW + 1)'(f2prng_pkg::MID_OFFSET);
  localparam logic [AW:0]   OffLag = (AW + 1)'(f2prng_pkg::TEMPER_LAG);

  logic [63:0] mem [STATE_DEPTH];

  logic [IW-1:0] idx_q;
  logic [AW-1:0] pos_q;
  logic [63:0]   extra_q;
  logic          out_valid_q;
  logic [63:0]   w_q, x_q, acc_q, cur_q, join_q, word_q, res_q, rdata_q, value_q;

  logic          idx_done;
  logic [AW-1:0] rd_addr, wr_addr, pos_nxt;
  logic [63:0]   wr_data;
  logic          wr_en;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [63:0]   twisted, extra_d, word_d;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW:0]   off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= DepthW) sum = sum - DepthW;
    return sum[AW-1:0];
  endfunction

  assign idx_done       = (idx_q == DepthI);
  assign sts_o.idx_done = idx_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign pos_nxt        = wrap_add(pos_q, OffOne);

  always_comb begin
    unique case (cmd_i.rd_sel)
      f2prng_pkg::RD_CUR: rd_addr = pos_q;
      f2prng_pkg::RD_NXT: rd_addr = pos_nxt;
      f2prng_pkg::RD_MID: rd_addr = wrap_add(pos_q, OffMid);
      f2prng_pkg::RD_LAG: rd_addr = wrap_add(pos_q, OffLag);
      default:            rd_addr = pos_q;
    endcase
  end

  // single write port: seed fill or generation update
  assign wr_en   = (cmd_i.sd_put && !idx_done) || cmd_i.gn_wr;
  assign wr_addr = cmd_i.gn_wr ? pos_q : idx_q[AW-1:0];
  assign wr_data = cmd_i.gn_wr ? word_q : w_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
  end

  // shared 32x32 multiplier, low 64 bits of the product built over three steps
  always_comb begin
    if (cmd_i.sd_mul1) begin
      mul_a = x_q[63:32];
      mul_b = f2prng_pkg::SEED_MULT[31:0];
    end else if (cmd_i.sd_mul2) begin
      mul_a = x_q[31:0];
      mul_b = f2prng_pkg::SEED_MULT[63:32];
    end else begin
      mul_a = x_q[31:0];
      mul_b = f2prng_pkg::SEED_MULT[31:0];
    end
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  assign twisted = {1'b0, join_q[63:1]} ^ (join_q[0] ? f2prng_pkg::TWIST_MATRIX : 64'd0);
  assign extra_d = twisted ^ rdata_q ^ (extra_q ^ (extra_q << f2prng_pkg::EXTRA_SHIFT));
  assign word_d  = join_q ^ (extra_d ^ (extra_d >> f2prng_pkg::STORE_SHIFT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pos_q       <= '0;
      extra_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.seed_load) begin
        idx_q <= '0;
      end else if (cmd_i.sd_put && !idx_done) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.sd_put && idx_done) begin
        pos_q   <= '0;
        extra_q <= w_q;
      end else if (cmd_i.gn_wr) begin
        pos_q <= pos_nxt;
      end
      if (cmd_i.gn_mix) extra_q <= extra_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      w_q <= seed_i;
    end else if (cmd_i.sd_mul2) begin
      w_q <= acc_q + {prod[31:0], 32'd0} + 64'(idx_q);
    end
    if (cmd_i.sd_mix) x_q <= w_q ^ (w_q >> f2prng_pkg::SEED_SHIFT);
    if (cmd_i.sd_mul0) begin
      acc_q <= prod;
    end else if (cmd_i.sd_mul1) begin
      acc_q <= acc_q + {prod[31:0], 32'd0};
    end
    if (cmd_i.gn_cap) cur_q <= rdata_q;
    if (cmd_i.gn_join) begin
      join_q <= (cur_q & f2prng_pkg::UPPER_MASK) | (rdata_q & f2prng_pkg::LOWER_MASK);
    end
    if (cmd_i.gn_mix) word_q <= word_d;
    if (cmd_i.gn_wr) begin
      res_q <= word_q ^ (word_q << f2prng_pkg::TEMPER_SHIFT)
             ^ (rdata_q & f2prng_pkg::TEMPER_MASK);
    end
    if (cmd_i.out_load) value_q <= cmd_i.out_zero ? 64'd0 : res_q;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < DepthW)
    else $error("position out of range");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sd_put |-> idx_q <= DepthI)
    else $error("seed index beyond state depth");
`endif

endmodule

### rtl/f2_linear_prng_64.sv
`timescale 1ns / 1ps
// Generate item: four reads through the single read port of the state memory, then
//   write-back and output load (waits for a free output register); input stalls till done.
// Generate before any seed: result zero, loaded when the output register is free.
// Seed item: no result; busy until every word is stored, set by one shared
//   32x32 multiplier used three times per word. Next item accepted once seeding ends.
// Reset: control, position and extra word cleared, not seeded; state memory not cleared.
module f2_linear_prng_64 #(
  parameter int STATE_DEPTH = 695
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [63:0] seed_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o
);

  // Controller sequences the seed fill (mix, three multiply steps, store per word)
  // and the generate steps (read current, next, mid and lag words, then write back).
  // The datapath owns the state memory, position, extra word and output register.
  f2prng_pkg::cmd_t cmd;
  f2prng_pkg::sts_t sts;

  f2prng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Output register parts the two channels: a finished item may sit in it while
  // the next input item is accepted and worked on.
  f2prng_dp #(
    .STATE_DEPTH (STATE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (seed_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o)
  );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 64-bit F2-linear generator, with a built-in predictor.
module tb_top;

  // Geometry and constants of the generator, kept apart from the RTL package on purpose.
  localparam int unsigned STATE_DEPTH = 695;
  localparam int unsigned MID_OFF     = 373;
  localparam int unsigned LAG_OFF     = 95;
  localparam logic [63:0] TWIST       = 64'h4fa9_ca36_f293_c9a9;
  localparam logic [63:0] TEMPER      = 64'h06fb_bee2_9aae_fd91;
  localparam logic [63:0] MULT        = 64'd6364136223846793005;
  localparam logic [63:0] LOW_BITS    = 64'h0000_7fff_ffff_ffff;

  localparam int unsigned ITEMS       = 1450;
  localparam int unsigned LONG_RUN    = 760;   // past one full lap of the store
  localparam int unsigned QUIET_LIMIT = 20000; // well above how long a seed alone keeps the ports quiet
  localparam int unsigned MAX_SHOWN   = 10;

  typedef enum logic {
    FN_SEED = 1'b0,
    FN_GEN  = 1'b1
  } func_e;

  // Directed row; `known` marks a result that needs no predictor.
  typedef struct {
    func_e       op;
    logic [63:0] seed;
    bit          known;
    logic [63:0] want;
  } row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        func_i      = 1'b0;
  logic [63:0] seed_i      = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] value_o;

  // Predictor state: the word store, the running position and the extra (lung) word.
  logic [63:0] gen_mem [STATE_DEPTH];
  int unsigned gen_pos    = 0;
  logic [63:0] gen_lung   = '0;
  bit          gen_seeded = 1'b0;

  logic [63:0] value_q [$];   // outputs still owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned quiet      = 0;
  int unsigned sent       = 0;
  bit          calm       = 1'b0; // no idling on either side while set

  // Opening rows: generates before any seed must give zero; then seeds at the
  // bit extremes (including both top bits set, which feed the >> 62 term),
  // back-to-back seeds, and generates after every seed but the first of that pair.
  row_t dir_rows [18] = '{
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b1, 64'h0},
    '{FN_GEN,  64'hffff_ffff_ffff_ffff, 1'b1, 64'h0},
    '{FN_GEN,  64'h5555_5555_5555_5555, 1'b1, 64'h0},
    '{FN_SEED, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_GEN,  64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_SEED, 64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{FN_GEN,  64'hffff_ffff_ffff_ffff, 1'b0, 64'h0},
    '{FN_SEED, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_SEED, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_SEED, 64'hc000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0},
    '{FN_SEED, 64'hdead_beef_cafe_f00d, 1'b0, 64'h0},
    '{FN_SEED, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
    '{FN_GEN,  64'h0000_0000_0000_0000, 1'b0, 64'h0}
  };

  f2_linear_prng_64 #(
    .STATE_DEPTH(STATE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .seed_i     (seed_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o)
  );

  always #10 clk_i = ~clk_i;

  // One term of the multiplicative seeding recurrence, mod 2^64.
  function automatic logic [63:0] seed_term(logic [63:0] w, logic [63:0] k);
    return MULT * (w ^ (w >> 62)) + k;
  endfunction

  // Seeding: fill every word, derive the lung from the next term, rewind.
  function automatic void fill_store(logic [63:0] s);
    gen_mem[0] = s;
    for (int unsigned i = 1; i < STATE_DEPTH; i++)
      gen_mem[i] = seed_term(gen_mem[i-1], 64'(i));
    gen_lung   = seed_term(gen_mem[STATE_DEPTH-1], 64'(STATE_DEPTH));
    gen_pos    = 0;
    gen_seeded = 1'b1;
  endfunction

  // One generate step; zero and no state change until seeded.
  function automatic logic [63:0] next_output();
    int unsigned cur, nxt, mid, lag;
    logic [63:0] joined, twisted, word, outv;
    if (!gen_seeded)
      return 64'h0;
    cur     = gen_pos;
    nxt     = (cur + 1) % STATE_DEPTH;
    mid     = (cur + MID_OFF) % STATE_DEPTH;
    lag     = (cur + LAG_OFF) % STATE_DEPTH;
    // upper 17 bits of this word, lower 47 of the next
    joined  = (gen_mem[cur] & ~LOW_BITS) | (gen_mem[nxt] & LOW_BITS);
    twisted = (joined >> 1) ^ (joined[0] ? TWIST : 64'h0);
    gen_lung = twisted ^ gen_mem[mid] ^ (gen_lung ^ (gen_lung << 37));
    word    = joined ^ (gen_lung ^ (gen_lung >> 14));
    gen_mem[cur] = word;
    outv    = word ^ (word << 6);
    outv   ^= gen_mem[lag] & TEMPER; // lag word never equals the one just rewritten
    gen_pos = nxt;
    return outv;
  endfunction

  // Present one item, wait for the handshake, then update the predictor.
  // Valid is only ever assigned once per step: lowered for a gap, or raised.
  task automatic put_item(func_e op, logic [63:0] s, bit known = 1'b0,
                          logic [63:0] want = 64'h0);
    int unsigned gap;
    logic [63:0] got;
    gap = 0;
    if (!calm)
      while (gap < 12 && $urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    seed_i     <= s;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    if (op == FN_SEED) begin
      fill_store(s);
    end else begin
      got = next_output();
      value_q.push_back(known ? want : got);
    end
  endtask

  // Drop valid and hold off until the block owes nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (value_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(9))
      0:       return 64'h0;
      1:       return '1;
      2:       return {2'b11, 30'($urandom), $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: check against the oldest owed value, then draw the next stall.
  always @(posedge clk_i) begin : rx_side
    logic [63:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (value_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected item: value %h with nothing owed", value_o);
      end else begin
        want = value_q.pop_front();
        if (value_o !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("value mismatch: expected %h, got %h", want, value_o);
        end
      end
    end
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stim
    int unsigned run;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      put_item(dir_rows[i].op, dir_rows[i].seed, dir_rows[i].known, dir_rows[i].want);

    // Empty the pipe once, then one long run that wraps the position and all offsets;
    // its first stretch has no idling at all.
    drain();
    put_item(FN_SEED, pick_seed());
    calm = 1'b1;
    for (int unsigned k = 0; k < LONG_RUN; k++) begin
      if (k == 250)
        calm = 1'b0;
      put_item(FN_GEN, {$urandom, $urandom});
    end

    // Short runs after fresh seeds; now and then seeds back to back.
    while (sent < ITEMS) begin
      put_item(FN_SEED, pick_seed());
      run = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 40);
      repeat (run) put_item(FN_GEN, {$urandom, $urandom});
    end
    put_item(FN_GEN, {$urandom, $urandom});

    in_valid_i <= 1'b0;
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && value_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### f2_linear_prng_64.f
rtl/f2prng_pkg.sv
rtl/f2prng_ctrl.sv
rtl/f2prng_dp.sv
rtl/f2_linear_prng_64.sv
tb/sv/tb_top.sv
